// ===== design/tcs_pkg.sv =====
// Package for the text console scrollback engine: sizes, codes, payload and
// controller/datapath interface types. No dependencies.
package tcs_pkg;

    localparam int HISTORY_LINES = 128;
    localparam int LINE_COLS     = 80;
    localparam int TAB_SPACES    = 4;

    localparam int CELL_DEPTH = HISTORY_LINES * LINE_COLS;
    localparam int ADDR_W     = $clog2(CELL_DEPTH);
    localparam int SLOT_W     = (HISTORY_LINES > 1) ? $clog2(HISTORY_LINES) : 1;
    localparam int COL_W      = $clog2(LINE_COLS);
    localparam int CNT_W      = $clog2(HISTORY_LINES + 1);
    localparam int CMP_W      = ((CNT_W > 8) ? CNT_W : 8) + 1;
    localparam int RED_W      = $clog2(HISTORY_LINES + 512) + 2;
    localparam int TAB_W      = $clog2(TAB_SPACES);
    localparam int CELL_W     = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_VISIBLE_ROWS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_ATTRIBUTE = 1'b1;

    localparam logic [7:0]  VROWS_RESET = 8'd10;
    localparam logic [15:0] ATTR_RESET  = 16'h0F00;

    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_UP     = 3'd1;
    localparam logic [2:0] OP_DOWN   = 3'd2;
    localparam logic [2:0] OP_LATEST = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] char_byte;
        logic [6:0] window_row;
        logic [6:0] window_col;
    } in_item_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [7:0]  scroll_depth;
        logic        is_scrolled;
    } out_item_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_TAB,
        S_NL,
        S_SWEEP,
        S_RD_RED,
        S_RD_CAP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic sweep_step;
        logic sweep_init;
        logic clear_state;
        logic glyph;
        logic glyph_space;
        logic nl_fill;
        logic cr;
        logic bs;
        logic up;
        logic down;
        logic latest;
        logic rd_setup;
        logic red_step;
        logic rd_issue;
        logic rd_capture;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       is_nl;
        logic       is_cr;
        logic       is_tab;
        logic       is_bs;
        logic       sweep_last;
        logic       col_last;
        logic       in_win;
        logic       red_ok;
        logic       out_free;
    } dp_status_t;

endpackage

// ===== design/text_console_scrollback.sv =====
// Text console scrollback engine: one result per command, one command at a time.
// Write/CR/BS/scroll act in decode; a tab writes TAB_SPACES spaces; a newline blanks
// the rest of the line; a read reduces the ring row in steps (out-of-window cells read 0);
// clear blanks every cell. A new command is taken only once the last result is loaded.
// Reset (aresetn, synchronous): blanking pass over every cell, s_ready low meanwhile.
// Top level; depends on tcs_pkg, tcs_ctrl, tcs_datapath, tcs_ram.
module text_console_scrollback (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [tcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tcs_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tcs_pkg::out_item_t             m_data
);

    tcs_pkg::dp_cmd_t    cmd;
    tcs_pkg::dp_status_t status;

    tcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcs_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== design/tcs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tcs_ctrl.sv =====
// Sequencer for the scrollback engine: decodes each transfer and steps the
// datapath through it. Depends on tcs_pkg.
module tcs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tcs_pkg::dp_status_t status,
    output tcs_pkg::dp_cmd_t    cmd
);

    tcs_pkg::state_t           state_reg, state_next;
    logic [tcs_pkg::TAB_W-1:0] tab_cnt_reg, tab_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tcs_pkg::S_INIT;
            tab_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            tab_cnt_reg <= tab_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        tab_cnt_next = tab_cnt_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            tcs_pkg::S_INIT: begin
                cmd.sweep_step = 1'b1;
                cmd.sweep_init = 1'b1;
                if (status.sweep_last) begin
                    state_next = tcs_pkg::S_IDLE;
                end
            end
            tcs_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = tcs_pkg::S_DECODE;
                end
            end
            tcs_pkg::S_DECODE: begin
                state_next = tcs_pkg::S_DONE;
                unique case (status.op)
                    tcs_pkg::OP_WRITE: begin
                        if (status.is_nl) begin
                            cmd.nl_fill = 1'b1;
                            if (!status.col_last) begin
                                state_next = tcs_pkg::S_NL;
                            end
                        end else if (status.is_cr) begin
                            cmd.cr = 1'b1;
                        end else if (status.is_tab) begin
                            cmd.glyph       = 1'b1;
                            cmd.glyph_space = 1'b1;
                            tab_cnt_next    = tcs_pkg::TAB_W'(tcs_pkg::TAB_SPACES - 1);
                            state_next      = tcs_pkg::S_TAB;
                        end else if (status.is_bs) begin
                            cmd.bs = 1'b1;
                        end else begin
                            cmd.glyph = 1'b1;
                        end
                    end
                    tcs_pkg::OP_UP:     cmd.up = 1'b1;
                    tcs_pkg::OP_DOWN:   cmd.down = 1'b1;
                    tcs_pkg::OP_LATEST: cmd.latest = 1'b1;
                    tcs_pkg::OP_READ: begin
                        cmd.rd_setup = 1'b1;
                        state_next   = tcs_pkg::S_RD_RED;
                    end
                    tcs_pkg::OP_CLEAR: begin
                        cmd.clear_state = 1'b1;
                        state_next      = tcs_pkg::S_SWEEP;
                    end
                    default: state_next = tcs_pkg::S_DONE;
                endcase
            end
            tcs_pkg::S_TAB: begin
                cmd.glyph       = 1'b1;
                cmd.glyph_space = 1'b1;
                tab_cnt_next    = tab_cnt_reg - 1'b1;
                if (tab_cnt_reg == tcs_pkg::TAB_W'(1)) begin
                    state_next = tcs_pkg::S_DONE;
                end
            end
            tcs_pkg::S_NL: begin
                cmd.nl_fill = 1'b1;
                if (status.col_last) begin
                    state_next = tcs_pkg::S_DONE;
                end
            end
            tcs_pkg::S_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last) begin
                    state_next = tcs_pkg::S_DONE;
                end
            end
            tcs_pkg::S_RD_RED: begin
                if (!status.in_win) begin
                    state_next = tcs_pkg::S_DONE;
                end else if (status.red_ok) begin
                    cmd.rd_issue = 1'b1;
                    state_next   = tcs_pkg::S_RD_CAP;
                end else begin
                    cmd.red_step = 1'b1;
                end
            end
            tcs_pkg::S_RD_CAP: begin
                cmd.rd_capture = 1'b1;
                state_next     = tcs_pkg::S_DONE;
            end
            tcs_pkg::S_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = tcs_pkg::S_IDLE;
                end
            end
            default: state_next = tcs_pkg::S_INIT;
        endcase
    end

    a_accept_decodes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == tcs_pkg::S_DECODE)
        else $error("accepted transfer not decoded");

    a_no_mem_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.sweep_step && (cmd.glyph || cmd.nl_fill || cmd.rd_issue)))
        else $error("sweep overlaps another cell access");

    a_tab_finishes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tcs_pkg::S_TAB && tab_cnt_reg == tcs_pkg::TAB_W'(1)
        |=> state_reg == tcs_pkg::S_DONE)
        else $error("tab expansion overran");

endmodule

// ===== design/tcs_datapath.sv =====
// Datapath of the scrollback engine: configuration, cursor and ring counters,
// view offset, read address reduction, cell store and result register.
// Depends on tcs_pkg and tcs_ram.
module tcs_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [tcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  tcs_pkg::in_item_t                 s_data,
    output tcs_pkg::out_item_t                m_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    input  tcs_pkg::dp_cmd_t                  cmd,
    output tcs_pkg::dp_status_t               status
);

    localparam int AW = tcs_pkg::ADDR_W;
    localparam int CW = tcs_pkg::CMP_W;
    localparam int RW = tcs_pkg::RED_W;

    logic [7:0]                   vrows_reg;
    logic [15:0]                  attr_reg;
    logic [31:0]                  line_reg, line_next;
    logic [tcs_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [tcs_pkg::CNT_W-1:0]    held_reg, held_next;
    logic [tcs_pkg::COL_W-1:0]    col_reg, col_next;
    logic [tcs_pkg::CNT_W-1:0]    off_reg, off_next;
    logic                         flag_reg, flag_next;
    logic [AW-1:0]                clr_addr_reg;
    logic                         in_win_reg;
    logic [RW-1:0]                red_reg;
    tcs_pkg::in_item_t            item_reg;
    logic [15:0]                  cell_reg;
    tcs_pkg::out_item_t           out_reg;
    logic                         m_valid_reg;

    logic                         col_last;
    logic                         sweep_last;
    logic                         advance;
    logic [CW-1:0]                held_ext, vr_ext, off_ext, span;
    logic [31:0]                  top;
    logic                         top_ge;
    logic                         row_ok, colr_ok;
    logic [RW-1:0]                red_init;
    logic                         red_neg, red_ok;
    logic [7:0]                   glyph_ch;
    logic [15:0]                  blank_cell;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr, line_addr, rd_addr;
    logic [15:0]                  mem_wdata, mem_rdata;

    assign col_last   = col_reg == tcs_pkg::COL_W'(tcs_pkg::LINE_COLS - 1);
    assign sweep_last = clr_addr_reg == AW'(tcs_pkg::CELL_DEPTH - 1);
    assign advance    = (cmd.glyph || cmd.nl_fill) && col_last;

    assign held_ext = CW'(held_reg);
    assign vr_ext   = CW'(vrows_reg);
    assign off_ext  = CW'(off_reg);
    assign span     = vr_ext + off_ext;
    assign top      = line_reg + 32'd1;
    assign top_ge   = top >= 32'(span);
    assign row_ok   = {1'b0, item_reg.window_row} < vrows_reg;
    assign colr_ok  = {2'b00, item_reg.window_col} < 9'(tcs_pkg::LINE_COLS);
    assign red_init = top_ge
        ? RW'(slot_reg) + RW'(1) + RW'(item_reg.window_row) - RW'(span)
        : RW'(item_reg.window_row);
    assign red_neg  = red_reg[RW-1];
    assign red_ok   = !red_neg && (red_reg < RW'(tcs_pkg::HISTORY_LINES));

    assign glyph_ch   = cmd.glyph_space ? tcs_pkg::CH_SPACE : item_reg.char_byte;
    assign blank_cell = {8'h00, tcs_pkg::CH_SPACE}
                      | (cmd.sweep_init ? tcs_pkg::ATTR_RESET : attr_reg);
    assign line_addr  = AW'(slot_reg) * AW'(tcs_pkg::LINE_COLS) + AW'(col_reg);
    assign rd_addr    = AW'(red_reg[tcs_pkg::SLOT_W-1:0]) * AW'(tcs_pkg::LINE_COLS)
                      + AW'(item_reg.window_col);

    assign mem_we    = cmd.sweep_step || cmd.glyph || cmd.nl_fill;
    assign mem_waddr = cmd.sweep_step ? clr_addr_reg : line_addr;
    assign mem_wdata = cmd.glyph ? ({8'h00, glyph_ch} | attr_reg) : blank_cell;

    tcs_ram #(
        .WIDTH (tcs_pkg::CELL_W),
        .DEPTH (tcs_pkg::CELL_DEPTH)
    ) u_cells (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (cmd.rd_issue),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    always_comb begin
        line_next = line_reg;
        slot_next = slot_reg;
        held_next = held_reg;
        col_next  = col_reg;
        off_next  = off_reg;
        flag_next = flag_reg;
        if (cmd.clear_state) begin
            line_next = '0;
            slot_next = '0;
            held_next = '0;
            col_next  = '0;
            off_next  = '0;
            flag_next = 1'b0;
        end
        if (cmd.glyph || cmd.nl_fill) begin
            col_next = col_last ? '0 : col_reg + 1'b1;
        end
        if (advance) begin
            line_next = line_reg + 32'd1;
            slot_next = (slot_reg == tcs_pkg::SLOT_W'(tcs_pkg::HISTORY_LINES - 1))
                      ? '0 : slot_reg + 1'b1;
            if (held_reg < tcs_pkg::CNT_W'(tcs_pkg::HISTORY_LINES)) begin
                held_next = held_reg + 1'b1;
            end
        end
        if (cmd.cr) begin
            col_next = '0;
        end
        if (cmd.bs && col_reg != '0) begin
            col_next = col_reg - 1'b1;
        end
        if (cmd.up && held_ext > vr_ext && off_ext < held_ext - vr_ext) begin
            off_next  = off_reg + 1'b1;
            flag_next = 1'b1;
        end
        if (cmd.down && off_reg != '0) begin
            off_next = off_reg - 1'b1;
            if (off_reg == tcs_pkg::CNT_W'(1)) begin
                flag_next = 1'b0;
            end
        end
        if (cmd.latest) begin
            off_next  = '0;
            flag_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vrows_reg    <= tcs_pkg::VROWS_RESET;
            attr_reg     <= tcs_pkg::ATTR_RESET;
            line_reg     <= '0;
            slot_reg     <= '0;
            held_reg     <= '0;
            col_reg      <= '0;
            off_reg      <= '0;
            flag_reg     <= 1'b0;
            clr_addr_reg <= '0;
            in_win_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == tcs_pkg::REG_VISIBLE_ROWS) begin
                vrows_reg <= cfg_wdata[7:0];
            end
            if (cfg_we && cfg_index == tcs_pkg::REG_CELL_ATTRIBUTE) begin
                attr_reg <= cfg_wdata[15:0];
            end
            line_reg <= line_next;
            slot_reg <= slot_next;
            held_reg <= held_next;
            col_reg  <= col_next;
            off_reg  <= off_next;
            flag_reg <= flag_next;
            if (cmd.sweep_step) begin
                clr_addr_reg <= sweep_last ? '0 : clr_addr_reg + 1'b1;
            end
            if (cmd.rd_setup) begin
                in_win_reg <= row_ok && colr_ok;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
            cell_reg <= '0;
        end
        if (cmd.rd_capture) begin
            cell_reg <= mem_rdata;
        end
        if (cmd.rd_setup) begin
            red_reg <= red_init;
        end else if (cmd.red_step) begin
            red_reg <= red_neg ? red_reg + RW'(tcs_pkg::HISTORY_LINES)
                               : red_reg - RW'(tcs_pkg::HISTORY_LINES);
        end
        if (cmd.out_load) begin
            out_reg.cell_value   <= cell_reg;
            out_reg.scroll_depth <= 8'(off_reg);
            out_reg.is_scrolled  <= flag_reg;
        end
    end

    assign m_data  = out_reg;
    assign m_valid = m_valid_reg;

    assign status.op         = item_reg.opcode;
    assign status.is_nl      = item_reg.char_byte == tcs_pkg::CH_NL;
    assign status.is_cr      = item_reg.char_byte == tcs_pkg::CH_CR;
    assign status.is_tab     = item_reg.char_byte == tcs_pkg::CH_TAB;
    assign status.is_bs      = item_reg.char_byte == tcs_pkg::CH_BS;
    assign status.sweep_last = sweep_last;
    assign status.col_last   = col_last;
    assign status.in_win     = in_win_reg;
    assign status.red_ok     = red_ok;
    assign status.out_free   = !m_valid_reg || m_ready;

    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg < tcs_pkg::COL_W'(tcs_pkg::LINE_COLS - 1) || col_last)
        else $error("cursor beyond line end");

    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tcs_pkg::CNT_W'(slot_reg) < tcs_pkg::CNT_W'(tcs_pkg::HISTORY_LINES))
        else $error("ring slot out of range");

    a_offset_held: assert property (@(posedge aclk) disable iff (!aresetn)
        off_reg <= held_reg && held_reg <= tcs_pkg::CNT_W'(tcs_pkg::HISTORY_LINES))
        else $error("view offset exceeds held history");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_valid_reg || m_ready)
        else $error("result overwritten before transfer");

endmodule
